@@ sv/qrgs_pkg.sv @@
// Shared types, codes and saturation helpers for the Gram-Schmidt QR block.
// Used by qrgs_ctrl, qrgs_dp and the top level; depends on nothing else.
package qrgs_pkg;

	localparam int IDX_W = 2;

	localparam logic REG_NUM_ROWS = 1'b0;
	localparam logic REG_NUM_COLS = 1'b1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLR_ALL,
		OP_ACC_CLR,
		OP_SQ_MUL,
		OP_SQ_ACC,
		OP_SQRT_START,
		OP_NORM_WR,
		OP_DIV_START,
		OP_Q_WR,
		OP_DOT_MUL,
		OP_DOT_ACC,
		OP_R_WR,
		OP_UPD_MUL,
		OP_UPD_WR,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] colj;
		logic             is_r;
		logic             last;
	} cmd_t;

	typedef struct packed {
		logic sqrt_busy;
		logic div_busy;
		logic norm_zero;
		logic out_hold;
	} status_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic fits;
		fits = (&v[63:31]) || !(|v[63:31]);
		if (fits) begin
			return v[31:0];
		end
		return v[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
	endfunction

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		if (v[32] == v[31]) begin
			return v[31:0];
		end
		return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
	endfunction

endpackage

@@ sv/qrgs_dp.sv @@
// Datapath of the Gram-Schmidt QR block: stores, multiplier, accumulator,
// square root and divider units, and the output register. Uses qrgs_pkg.
module qrgs_dp #(
	parameter int MAX_ROWS  = 4,
	parameter int MAX_COLS  = 4,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  qrgs_pkg::cmd_t     cmd,
	output qrgs_pkg::status_t  status,
	input  logic signed [31:0] elem_value,
	output logic signed [31:0] out_value,
	output logic               out_is_r,
	output logic [1:0]         out_row,
	output logic [1:0]         out_col,
	output logic               out_last,
	output logic               zero_norm_seen,
	output logic               out_valid,
	input  logic               out_stall
);
	import qrgs_pkg::*;

	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int NB  = 32 + FRAC_BITS;
	localparam int DCW = $clog2(NB + 1);

	logic signed [31:0] work_q  [MAX_ROWS][MAX_COLS];
	logic signed [31:0] qmat_q  [MAX_ROWS][MAX_COLS];
	logic signed [31:0] rmat_q  [MAX_ROWS][MAX_COLS];

	logic signed [63:0] prod_q;
	logic signed [63:0] acc_q;
	logic signed [31:0] norm_q;
	logic signed [31:0] dot_q;
	logic               zflag_q;

	logic [63:0]        sx_q, sr_q, sb_q;
	logic [NB-1:0]      dq_q;
	logic [31:0]        rem_q;
	logic               neg_q;
	logic [DCW-1:0]     dcnt_q;

	logic [RW-1:0]      a_row;
	logic [CW-1:0]      a_col, w_col;
	logic signed [31:0] w_rd, q_rd, r_rd;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_res;
	logic [64:0]        usum;
	logic signed [63:0] ssum, ssat;
	logic               sovf;
	logic signed [31:0] dot_nar, prod_nar, upd_val, root_sat, div_val;
	logic [63:0]        sq_t;
	logic [31:0]        dv_t;
	logic               dv_ge;
	logic [31:0]        mag;

	assign a_row = cmd.row[RW-1:0];
	assign a_col = cmd.col[CW-1:0];
	assign w_col = (cmd.op == OP_DOT_MUL || cmd.op == OP_UPD_MUL || cmd.op == OP_UPD_WR)
		? cmd.colj[CW-1:0] : a_col;

	assign w_rd = work_q[a_row][w_col];
	assign q_rd = qmat_q[a_row][a_col];
	assign r_rd = rmat_q[a_row][a_col];

	assign mul_a   = (cmd.op == OP_SQ_MUL) ? w_rd : q_rd;
	assign mul_b   = (cmd.op == OP_UPD_MUL) ? dot_q : w_rd;
	assign mul_res = mul_a * mul_b;

	assign usum = {1'b0, acc_q} + {1'b0, prod_q};
	assign ssum = acc_q + prod_q;
	assign sovf = (acc_q[63] == prod_q[63]) && (ssum[63] != acc_q[63]);
	assign ssat = sovf ? (acc_q[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : ssum;

	assign dot_nar  = sat32(acc_q >>> FRAC_BITS);
	assign prod_nar = sat32(prod_q >>> FRAC_BITS);
	assign upd_val  = sat33({w_rd[31], w_rd} - {prod_nar[31], prod_nar});
	assign root_sat = sr_q[31] ? 32'sh7fff_ffff : sr_q[31:0];

	// One root digit per cycle.
	assign sq_t = sr_q + sb_q;

	// One quotient bit per cycle; the remainder stays below the norm.
	assign dv_t  = {rem_q[30:0], dq_q[NB-1]};
	assign dv_ge = dv_t >= {1'b0, norm_q[30:0]};
	assign mag   = w_rd[31] ? (~w_rd + 32'd1) : w_rd;

	always_comb begin
		if (!neg_q) begin
			div_val = (|dq_q[NB-1:31]) ? 32'sh7fff_ffff : dq_q[31:0];
		end else if ((|dq_q[NB-1:32]) || (dq_q[31] && (|dq_q[30:0]))) begin
			div_val = 32'sh8000_0000;
		end else begin
			div_val = ~dq_q[31:0] + 32'd1;
		end
	end

	assign status.sqrt_busy = |sb_q;
	assign status.div_busy  = |dcnt_q;
	assign status.norm_zero = (norm_q == 32'sd0);
	assign status.out_hold  = out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_q      <= '0;
			dcnt_q    <= '0;
			zflag_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.op == OP_SQRT_START) begin
				sb_q <= 64'd1 << 62;
			end else if (|sb_q) begin
				sb_q <= sb_q >> 2;
			end
			if (cmd.op == OP_DIV_START) begin
				dcnt_q <= DCW'(NB);
			end else if (|dcnt_q) begin
				dcnt_q <= dcnt_q - DCW'(1);
			end
			if (cmd.op == OP_CLR_ALL) begin
				zflag_q <= 1'b0;
			end else if (cmd.op == OP_NORM_WR && root_sat == 32'sd0) begin
				zflag_q <= 1'b1;
			end
			if (cmd.op == OP_EMIT) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				work_q[a_row][a_col] <= elem_value;
			end
			OP_CLR_ALL, OP_ACC_CLR: begin
				acc_q <= '0;
			end
			OP_SQ_MUL, OP_DOT_MUL, OP_UPD_MUL: begin
				prod_q <= mul_res;
			end
			OP_SQ_ACC: begin
				acc_q <= usum[64] ? {64{1'b1}} : usum[63:0];
			end
			OP_SQRT_START: begin
				sx_q <= acc_q;
				sr_q <= '0;
			end
			OP_NORM_WR: begin
				norm_q               <= root_sat;
				rmat_q[a_row][a_col] <= root_sat;
			end
			OP_DIV_START: begin
				dq_q  <= {mag, {FRAC_BITS{1'b0}}};
				rem_q <= '0;
				neg_q <= w_rd[31];
			end
			OP_Q_WR: begin
				qmat_q[a_row][a_col] <= (norm_q == 32'sd0) ? 32'sd0 : div_val;
			end
			OP_DOT_ACC: begin
				acc_q <= ssat;
			end
			OP_R_WR: begin
				dot_q                <= dot_nar;
				rmat_q[a_row][a_col] <= dot_nar;
			end
			OP_UPD_WR: begin
				work_q[a_row][w_col] <= upd_val;
			end
			OP_EMIT: begin
				out_value      <= !cmd.is_r ? q_rd : ((cmd.row > cmd.col) ? 32'sd0 : r_rd);
				out_is_r       <= cmd.is_r;
				out_row        <= cmd.row;
				out_col        <= cmd.col;
				out_last       <= cmd.last;
				zero_norm_seen <= zflag_q;
			end
			default: begin
			end
		endcase
		if (|sb_q) begin
			if (sx_q >= sq_t) begin
				sx_q <= sx_q - sq_t;
				sr_q <= (sr_q >> 1) + sb_q;
			end else begin
				sr_q <= sr_q >> 1;
			end
		end
		if (|dcnt_q) begin
			rem_q <= dv_ge ? (dv_t - {1'b0, norm_q[30:0]}) : dv_t;
			dq_q  <= {dq_q[NB-2:0], dv_ge};
		end
	end

`ifndef ASSERT_OFF
	a_one_unit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(status.sqrt_busy && status.div_busy))
		else $error("square root and divider busy at once");

	a_last_is_r: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> out_is_r)
		else $error("last marker on an element of Q");

	a_lower_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_is_r && (out_row > out_col) |-> out_value == 32'sd0)
		else $error("nonzero R element below the diagonal");

	a_div_norm: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_DIV_START |-> norm_q != 32'sd0)
		else $error("division started with zero norm");
`endif

endmodule

@@ sv/qrgs_ctrl.sv @@
// Controller of the Gram-Schmidt QR block: configuration registers, load,
// factorization and emission sequencing. Uses qrgs_pkg; drives qrgs_dp.
module qrgs_ctrl #(
	parameter int MAX_ROWS = 4,
	parameter int MAX_COLS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic              cfg_index,
	input  logic [2:0]        cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	output qrgs_pkg::cmd_t    cmd,
	input  qrgs_pkg::status_t status
);
	import qrgs_pkg::*;

	typedef enum logic [4:0] {
		S_LOAD, S_START, S_COL_START, S_SQ_MUL, S_SQ_ACC, S_SQRT_GO, S_SQRT_WAIT,
		S_NORM, S_Q_PREP, S_DIV_WAIT, S_Q_WR, S_DOT_START, S_DOT_MUL, S_DOT_ACC,
		S_R_WR, S_UPD_MUL, S_UPD_WR, S_EMIT
	} state_t;

	state_t           state_q;
	logic [2:0]       num_rows_q, num_cols_q;
	logic [IDX_W-1:0] k_q, i_q, j_q;
	logic             is_r_q;
	logic [2:0]       m3, n3a, n3;
	logic [IDX_W-1:0] m_last, n_last;
	logic             accept, k_end, i_end, j_end, emit_ok;

	always_comb begin
		m3 = (num_rows_q == 3'd0) ? 3'd1
			: (num_rows_q > 3'(MAX_ROWS)) ? 3'(MAX_ROWS) : num_rows_q;
		n3a = (num_cols_q == 3'd0) ? 3'd1
			: (num_cols_q > 3'(MAX_COLS)) ? 3'(MAX_COLS) : num_cols_q;
		n3 = (n3a > m3) ? m3 : n3a;
	end

	assign m_last  = IDX_W'(m3 - 3'd1);
	assign n_last  = IDX_W'(n3 - 3'd1);
	assign in_stall = (state_q != S_LOAD);
	assign accept  = in_valid && !in_stall;
	assign k_end   = (k_q == m_last);
	assign i_end   = (i_q == n_last);
	assign j_end   = (j_q == n_last);
	assign emit_ok = !status.out_hold;

	always_comb begin
		cmd.op   = OP_NONE;
		cmd.row  = k_q;
		cmd.col  = i_q;
		cmd.colj = j_q;
		cmd.is_r = is_r_q;
		cmd.last = is_r_q && k_end && i_end;
		cmd.last = is_r_q && (k_q == n_last) && i_end;
		case (state_q)
			S_LOAD:      cmd.op = accept ? OP_LOAD : OP_NONE;
			S_START:     cmd.op = OP_CLR_ALL;
			S_COL_START: cmd.op = OP_ACC_CLR;
			S_SQ_MUL:    cmd.op = OP_SQ_MUL;
			S_SQ_ACC:    cmd.op = OP_SQ_ACC;
			S_SQRT_GO:   cmd.op = OP_SQRT_START;
			S_NORM: begin
				cmd.op  = OP_NORM_WR;
				cmd.row = i_q;
			end
			S_Q_PREP:    cmd.op = status.norm_zero ? OP_NONE : OP_DIV_START;
			S_Q_WR:      cmd.op = OP_Q_WR;
			S_DOT_START: cmd.op = OP_ACC_CLR;
			S_DOT_MUL:   cmd.op = OP_DOT_MUL;
			S_DOT_ACC:   cmd.op = OP_DOT_ACC;
			S_R_WR: begin
				cmd.op  = OP_R_WR;
				cmd.row = i_q;
				cmd.col = j_q;
			end
			S_UPD_MUL:   cmd.op = OP_UPD_MUL;
			S_UPD_WR:    cmd.op = OP_UPD_WR;
			S_EMIT:      cmd.op = emit_ok ? OP_EMIT : OP_NONE;
			default:     cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			num_rows_q <= 3'd4;
			num_cols_q <= 3'd4;
			k_q        <= '0;
			i_q        <= '0;
			j_q        <= '0;
			is_r_q     <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (cfg_write) begin
						if (cfg_index == REG_NUM_ROWS) begin
							num_rows_q <= cfg_data;
						end else begin
							num_cols_q <= cfg_data;
						end
						k_q <= '0;
						i_q <= '0;
					end else if (accept) begin
						if (i_end) begin
							i_q <= '0;
							if (k_end) begin
								k_q     <= '0;
								state_q <= S_START;
							end else begin
								k_q <= k_q + 1'b1;
							end
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
				end
				S_START, S_COL_START: state_q <= S_SQ_MUL;
				S_SQ_MUL: state_q <= S_SQ_ACC;
				S_SQ_ACC: begin
					if (k_end) begin
						k_q     <= '0;
						state_q <= S_SQRT_GO;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_SQ_MUL;
					end
				end
				S_SQRT_GO: state_q <= S_SQRT_WAIT;
				S_SQRT_WAIT: begin
					if (!status.sqrt_busy) begin
						state_q <= S_NORM;
					end
				end
				S_NORM: state_q <= S_Q_PREP;
				S_Q_PREP: state_q <= status.norm_zero ? S_Q_WR : S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (!status.div_busy) begin
						state_q <= S_Q_WR;
					end
				end
				S_Q_WR: begin
					if (k_end) begin
						k_q <= '0;
						if (i_end) begin
							i_q     <= '0;
							is_r_q  <= 1'b0;
							state_q <= S_EMIT;
						end else begin
							j_q     <= i_q + 1'b1;
							state_q <= S_DOT_START;
						end
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_Q_PREP;
					end
				end
				S_DOT_START: state_q <= S_DOT_MUL;
				S_DOT_MUL: state_q <= S_DOT_ACC;
				S_DOT_ACC: begin
					if (k_end) begin
						k_q     <= '0;
						state_q <= S_R_WR;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_DOT_MUL;
					end
				end
				S_R_WR: state_q <= S_UPD_MUL;
				S_UPD_MUL: state_q <= S_UPD_WR;
				S_UPD_WR: begin
					if (k_end) begin
						k_q <= '0;
						if (j_end) begin
							i_q     <= i_q + 1'b1;
							state_q <= S_COL_START;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_DOT_START;
						end
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_UPD_MUL;
					end
				end
				S_EMIT: begin
					if (emit_ok) begin
						if (i_end) begin
							i_q <= '0;
							if (is_r_q) begin
								if (k_q == n_last) begin
									k_q     <= '0;
									is_r_q  <= 1'b0;
									state_q <= S_LOAD;
								end else begin
									k_q <= k_q + 1'b1;
								end
							end else if (k_end) begin
								k_q    <= '0;
								is_r_q <= 1'b1;
							end else begin
								k_q <= k_q + 1'b1;
							end
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_LOAD |-> state_q == S_LOAD && in_valid)
		else $error("element stored outside the load phase");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EMIT |-> !status.out_hold)
		else $error("result loaded over a stalled result");

	a_j_after_i: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DOT_MUL || state_q == S_UPD_WR) |-> j_q > i_q)
		else $error("projection onto an earlier column");
`endif

endmodule

@@ sv/qr_decomposition_gram_schmidt.sv @@
// Top level of the fixed-point QR factorization by modified Gram-Schmidt.
// Joins qrgs_ctrl and qrgs_dp; uses qrgs_pkg.
//
// Usage: matrix elements (signed Q16.16, row-major) arrive on the input
// channel (in_valid, in_stall, elem_value); one element is taken per cycle
// while the block is loading. After the transfer of the last element,
// in_stall stays high while the factorization runs and the results leave.
// Per column i the block forms the sum of squares, takes its square root in
// the one-digit-per-cycle square root unit, forms that column of Q in the
// one-bit-per-cycle divider, and then runs the projections onto the later
// columns; the divider dominates the run time of the factorization.
// The results are m*n elements of Q and then n*n elements of R (zeros below
// the diagonal, the last one flagged by out_last), one per cycle through a
// single output register. When the receiver raises out_stall the held
// result stays unchanged and emission pauses. Loading of the next matrix
// starts once the final result has entered the output register.
// num_rows and num_cols are written through cfg_write/cfg_index/cfg_data
// while the block loads; a write discards a partly loaded matrix.
// Reset returns both sizes to 4, empties the output and starts loading.
module qr_decomposition_gram_schmidt #(
	parameter int MAX_ROWS  = 4,
	parameter int MAX_COLS  = 4,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [2:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] elem_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_value,
	output logic               out_is_r,
	output logic [1:0]         out_row,
	output logic [1:0]         out_col,
	output logic               out_last,
	output logic               zero_norm_seen
);
	import qrgs_pkg::*;

	cmd_t    cmd;
	status_t status;

	// The controller sequences every step; the datapath only executes them.
	qrgs_ctrl #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.status    (status)
	);

	qrgs_dp #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_COLS  (MAX_COLS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.elem_value     (elem_value),
		.out_value      (out_value),
		.out_is_r       (out_is_r),
		.out_row        (out_row),
		.out_col        (out_col),
		.out_last       (out_last),
		.zero_norm_seen (zero_norm_seen),
		.out_valid      (out_valid),
		.out_stall      (out_stall)
	);

endmodule
